/* hdl/mfc_pkg.sv */
package mfc_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int MAX_DATA    = 64;

    localparam int QIDX_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int OFS_W     = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
    localparam int SIZE_W    = 7;
    localparam int PAY_DEPTH = QUEUE_DEPTH * MAX_DATA;
    localparam int PAY_AW    = $clog2(PAY_DEPTH);
    localparam int HDR_W     = 8 + SIZE_W + 8;

    localparam logic [1:0] KIND_PUSH    = 2'd0;
    localparam logic [1:0] KIND_READ    = 2'd1;
    localparam logic [1:0] KIND_DISCARD = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_TOOSMALL = 3'd3;
    localparam logic [2:0] ST_TRUNC    = 3'd4;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        cmd;
        logic [7:0]        data_byte;
        logic              has_byte;
        logic              last;
        logic [SIZE_W-1:0] read_limit;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        status;
        logic [7:0]        cmd_out;
        logic [SIZE_W-1:0] size_out;
        logic [7:0]        checksum_out;
        logic [7:0]        byte_out;
        logic              byte_valid;
        logic              last_out;
    } t_out_item;

    typedef struct packed {
        logic [7:0]        cmd;
        logic [SIZE_W-1:0] size;
        logic [7:0]        sum;
    } t_hdr;

    typedef struct packed {
        logic do_push;
        logic do_discard;
        logic rd_single;
        logic rd_start;
        logic rd_emit;
        logic rd_next;
    } t_ctl_cmd;

    typedef struct packed {
        logic out_free;
        logic rd_single;
        logic last_byte;
    } t_dp_stat;

endpackage

/* hdl/mfc_ram.sv */
module mfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/mfc_dp.sv */
module mfc_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mfc_pkg::t_in_item  i_item,
    input  mfc_pkg::t_ctl_cmd  i_cmd,
    input  logic               i_out_stall,
    output mfc_pkg::t_dp_stat  o_stat,
    output logic               o_out_valid,
    output mfc_pkg::t_out_item o_out_item
);

    logic [mfc_pkg::QIDX_W-1:0] r_head, n_head;
    logic [mfc_pkg::QIDX_W-1:0] r_tail, n_tail;
    logic [mfc_pkg::CNT_W-1:0]  r_count, n_count;
    logic [mfc_pkg::SIZE_W-1:0] r_ofs;
    logic [7:0]                 r_sum;
    logic [7:0]                 r_push_cmd;
    logic                       r_push_active;
    logic                       r_push_rej;
    logic                       r_ovf;
    logic [mfc_pkg::OFS_W-1:0]  r_rd_idx;
    logic                       r_out_valid;
    mfc_pkg::t_out_item         r_out_item, n_out_item;
    mfc_pkg::t_hdr              r_hdr_mem [mfc_pkg::QUEUE_DEPTH];

    mfc_pkg::t_hdr              head_hdr;
    logic                       empty, full, too_big, out_free, last_byte;
    logic                       first, p_rej, p_ovf, n_ovf;
    logic [mfc_pkg::SIZE_W-1:0] p_ofs, n_ofs;
    logic [7:0]                 p_sum, n_sum, p_cmd;
    logic                       wr_en, rd_en, ld, commit;
    logic [mfc_pkg::PAY_AW-1:0] wr_addr, rd_addr, rd_base;
    logic [7:0]                 rd_data;

    assign head_hdr  = r_hdr_mem[r_head];
    assign empty     = (r_count == '0);
    assign full      = (r_count >= mfc_pkg::CNT_W'(mfc_pkg::QUEUE_DEPTH));
    assign too_big   = (head_hdr.size > i_item.read_limit);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign last_byte = ((mfc_pkg::SIZE_W'(r_rd_idx) + mfc_pkg::SIZE_W'(1)) == head_hdr.size);

    assign o_stat.out_free  = out_free;
    assign o_stat.rd_single = empty || too_big || (head_hdr.size == '0);
    assign o_stat.last_byte = last_byte;

    // first word of a message restarts the running state
    always_comb begin
        first = !r_push_active;
        p_rej = first ? full : r_push_rej;
        p_ofs = first ? '0 : r_ofs;
        p_sum = first ? i_item.cmd : r_sum;
        p_ovf = first ? 1'b0 : r_ovf;
        p_cmd = first ? i_item.cmd : r_push_cmd;
        n_ofs = p_ofs;
        n_sum = p_sum;
        n_ovf = p_ovf;
        wr_en = 1'b0;
        if (i_item.has_byte) begin
            if (p_ofs < mfc_pkg::SIZE_W'(mfc_pkg::MAX_DATA)) begin
                wr_en = i_cmd.do_push && !p_rej;
                n_sum = p_sum + i_item.data_byte;
                n_ofs = p_ofs + mfc_pkg::SIZE_W'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    assign wr_addr = mfc_pkg::PAY_AW'(r_tail) * mfc_pkg::PAY_AW'(mfc_pkg::MAX_DATA)
                   + mfc_pkg::PAY_AW'(p_ofs);
    assign rd_base = mfc_pkg::PAY_AW'(r_head) * mfc_pkg::PAY_AW'(mfc_pkg::MAX_DATA);
    assign rd_addr = i_cmd.rd_next
                   ? rd_base + mfc_pkg::PAY_AW'(r_rd_idx) + mfc_pkg::PAY_AW'(1)
                   : rd_base;
    assign rd_en   = i_cmd.rd_start || i_cmd.rd_next;

    mfc_ram #(
        .WIDTH (8),
        .DEPTH (mfc_pkg::PAY_DEPTH)
    ) u_payload (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_item.data_byte),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign commit = i_cmd.do_push && i_item.last && !p_rej;

    always_comb begin
        n_tail  = r_tail;
        n_head  = r_head;
        n_count = r_count;
        if (commit) begin
            n_tail  = (r_tail == mfc_pkg::QIDX_W'(mfc_pkg::QUEUE_DEPTH - 1))
                    ? '0 : r_tail + mfc_pkg::QIDX_W'(1);
            n_count = r_count + mfc_pkg::CNT_W'(1);
        end
        if (i_cmd.do_discard && !empty) begin
            n_head  = (r_head == mfc_pkg::QIDX_W'(mfc_pkg::QUEUE_DEPTH - 1))
                    ? '0 : r_head + mfc_pkg::QIDX_W'(1);
            n_count = r_count - mfc_pkg::CNT_W'(1);
        end
    end

    always_comb begin
        ld         = 1'b0;
        n_out_item = '0;
        if (i_cmd.do_push && i_item.last) begin
            ld                      = 1'b1;
            n_out_item.status       = p_rej ? mfc_pkg::ST_FULL
                                    : (n_ovf ? mfc_pkg::ST_TRUNC : mfc_pkg::ST_OK);
            // a rejected message reports the command of its closing word
            n_out_item.cmd_out      = p_rej ? i_item.cmd : p_cmd;
            n_out_item.size_out     = n_ofs;
            n_out_item.checksum_out = n_sum;
            n_out_item.last_out     = 1'b1;
        end
        if (i_cmd.do_discard) begin
            ld                  = 1'b1;
            n_out_item.status   = empty ? mfc_pkg::ST_EMPTY : mfc_pkg::ST_OK;
            n_out_item.last_out = 1'b1;
        end
        if (i_cmd.rd_single) begin
            ld                  = 1'b1;
            n_out_item.last_out = 1'b1;
            if (empty) begin
                n_out_item.status = mfc_pkg::ST_EMPTY;
            end else begin
                n_out_item.status       = too_big ? mfc_pkg::ST_TOOSMALL : mfc_pkg::ST_OK;
                n_out_item.cmd_out      = head_hdr.cmd;
                n_out_item.size_out     = head_hdr.size;
                n_out_item.checksum_out = head_hdr.sum;
            end
        end
        if (i_cmd.rd_emit) begin
            ld                      = 1'b1;
            n_out_item.status       = mfc_pkg::ST_OK;
            n_out_item.cmd_out      = head_hdr.cmd;
            n_out_item.size_out     = head_hdr.size;
            n_out_item.checksum_out = head_hdr.sum;
            n_out_item.byte_out     = rd_data;
            n_out_item.byte_valid   = 1'b1;
            n_out_item.last_out     = last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head        <= '0;
            r_tail        <= '0;
            r_count       <= '0;
            r_ofs         <= '0;
            r_sum         <= '0;
            r_push_cmd    <= '0;
            r_push_active <= 1'b0;
            r_push_rej    <= 1'b0;
            r_ovf         <= 1'b0;
            r_rd_idx      <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            if (i_cmd.do_push) begin
                r_push_active <= !i_item.last;
                r_push_rej    <= p_rej;
                r_ofs         <= n_ofs;
                r_sum         <= n_sum;
                r_ovf         <= n_ovf;
                r_push_cmd    <= p_cmd;
            end
            if (i_cmd.rd_start) begin
                r_rd_idx <= '0;
            end else if (i_cmd.rd_next) begin
                r_rd_idx <= r_rd_idx + mfc_pkg::OFS_W'(1);
            end
            if (ld) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_hdr_mem[r_tail] <= '{cmd: p_cmd, size: n_ofs, sum: n_sum};
        end
        if (ld) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld |-> out_free)
        else $error("output register loaded while a word is still held");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mfc_pkg::CNT_W'(mfc_pkg::QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == r_tail))
        else $error("empty queue with head and tail apart");

    a_ofs_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ofs <= mfc_pkg::SIZE_W'(mfc_pkg::MAX_DATA))
        else $error("write offset above payload limit");

endmodule

/* hdl/mfc_ctrl.sv */
module mfc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_kind,
    input  mfc_pkg::t_dp_stat i_stat,
    output logic              o_in_stall,
    output mfc_pkg::t_ctl_cmd o_cmd
);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_STREAM = 1'b1;

    logic r_state, n_state;
    logic accept;

    assign o_in_stall = (r_state != S_IDLE) || !i_stat.out_free;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_kind)
                        mfc_pkg::KIND_PUSH: begin
                            o_cmd.do_push = 1'b1;
                        end
                        mfc_pkg::KIND_READ: begin
                            if (i_stat.rd_single) begin
                                o_cmd.rd_single = 1'b1;
                            end else begin
                                o_cmd.rd_start = 1'b1;
                                n_state        = S_STREAM;
                            end
                        end
                        mfc_pkg::KIND_DISCARD: begin
                            o_cmd.do_discard = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_STREAM: begin
                // one payload word per free output slot, next read issued alongside
                if (i_stat.out_free) begin
                    o_cmd.rd_emit = 1'b1;
                    if (i_stat.last_byte) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.rd_next = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_stream_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STREAM) |-> !(o_cmd.do_push || o_cmd.do_discard || o_cmd.rd_single))
        else $error("new work started during a payload stream");

    a_stream_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STREAM && n_state == S_IDLE) |-> i_stat.last_byte && o_cmd.rd_emit)
        else $error("payload stream left before its last word");

    a_stream_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STREAM) |-> o_in_stall)
        else $error("input open during a payload stream");

endmodule

/* hdl/message_fifo_with_checksum.sv */
// channel  | valid        | stall        | word
// ---------+--------------+--------------+------------------------------
// input    | i_in_valid   | o_in_stall   | i_in_item  (mfc_pkg::t_in_item)
// output   | o_out_valid  | i_out_stall  | o_out_item (mfc_pkg::t_out_item)
//
// push, discard, kind 3 and single-word reads are handled in the idle state
// a streamed read first issues a payload ram read, then emits its payload bytes in order
//   while the output is not stalled, paced by the payload ram read port
// no new input word is taken during a stream or while a result is held stalled
// reset is synchronous, active low; queue stores hold garbage until written
module message_fifo_with_checksum (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mfc_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mfc_pkg::t_out_item o_out_item
);

    mfc_pkg::t_ctl_cmd cmd;
    mfc_pkg::t_dp_stat stat;

    mfc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_in_item.kind),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    mfc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in_item),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
